// ===== hdl/dio_port_group_controller_top_assert.svh =====
// Assertion macros used by the checker of the port group controller.
`ifndef DIO_PORT_GROUP_CONTROLLER_TOP_ASSERT_SVH
`define DIO_PORT_GROUP_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dpg_pkg.sv =====
// Types, codes and constants of the digital I/O port group controller.
package dpg_pkg;

  localparam int unsigned GROUPS    = 2;
  localparam int unsigned GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned NUM_CFG   = 2;

  // grouping modes
  localparam logic [1:0] MODE_3X8  = 2'd0;
  localparam logic [1:0] MODE_2X12 = 2'd1;
  localparam logic [1:0] MODE_1X24 = 2'd2;
  localparam logic [1:0] MODE_16P8 = 2'd3;
  localparam logic [1:0] MODE_RESET = MODE_1X24;

  // direction codes: bit 0 low nibble input, bit 1 high nibble input
  localparam logic [1:0] DIR_ALL_OUT = 2'd0;
  localparam logic [1:0] DIR_LOW_IN  = 2'd1;
  localparam logic [1:0] DIR_HIGH_IN = 2'd2;
  localparam logic [1:0] DIR_ALL_IN  = 2'd3;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_GROUP = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHAN  = 2'd2;

  // channels
  localparam logic [1:0] CHAN_0 = 2'd0;
  localparam logic [1:0] CHAN_1 = 2'd1;
  localparam logic [1:0] CHAN_2 = 2'd2;

  // mode-0 control word bits
  localparam logic [7:0] CTRL_BASE   = 8'h80;
  localparam logic [7:0] CTRL_A_IN   = 8'h10;
  localparam logic [7:0] CTRL_B_IN   = 8'h02;
  localparam logic [7:0] CTRL_CHI_IN = 8'h08;
  localparam logic [7:0] CTRL_CLO_IN = 8'h01;

  typedef struct packed {
    logic        req_type;
    logic        group_sel;
    logic [1:0]  channel;
    logic [23:0] write_value;
    logic [7:0]  pins_a;
    logic [7:0]  pins_b;
    logic [7:0]  pins_c;
  } req_t;

  typedef struct packed {
    logic [1:0] dir_a;
    logic [1:0] dir_b;
    logic [1:0] dir_c;
    logic [7:0] latch_a;
    logic [7:0] latch_b;
    logic [7:0] latch_c;
  } grp_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] read_value;
    logic [7:0]  control_byte;
    logic [7:0]  latch_a;
    logic [7:0]  latch_b;
    logic [7:0]  latch_c;
    logic        direction_changed;
  } res_t;

  function automatic logic [7:0] ctrl_of(input grp_state_t s);
    logic [7:0] c;
    c = CTRL_BASE;
    if (s.dir_a == DIR_ALL_IN) c = c | CTRL_A_IN;
    if (s.dir_b == DIR_ALL_IN) c = c | CTRL_B_IN;
    if ((s.dir_c & DIR_HIGH_IN) != DIR_ALL_OUT) c = c | CTRL_CHI_IN;
    if ((s.dir_c & DIR_LOW_IN) != DIR_ALL_OUT) c = c | CTRL_CLO_IN;
    return c;
  endfunction

endpackage

// ===== hdl/dio_port_group_controller_top.sv =====
// Top level of the digital I/O port group controller.
// Usage:
//   Requests arrive as words on the s_axis channel; each gives exactly one
//   result word on the m_axis channel, in order. A request names a group,
//   a channel and a write or read; the result carries status, the read
//   value, the group's mode-0 control byte, its three latches and a flag
//   that marks a change of port direction.
//   The APB port holds the grouping mode of each group (byte address 0 for
//   group 0, 4 for group 1); write it only while no request is in flight.
//   Path: a request is taken into the input register, and its result is
//   then held in the result register that drives m_axis.
//   Throughput: one word per cycle while the receiver takes results; the
//   decode between the two registers is a short mux path and the group state
//   is read and written back in the same cycle.
//   Reset: modes return to 1x24, all ports to input, latches to zero, both
//   pipeline registers empty.
//   When the receiver stalls, the result register holds its word and the
//   input register keeps one more request; s_axis_tready then drops.
module dio_port_group_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // write_value[23:0], pins_a, pins_b, pins_c
  input  logic [3:0]  s_axis_tuser,  // req_type, group_sel, channel[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // read_value[23:0], control_byte, latch_a/b/c
  output logic [2:0]  m_axis_tuser   // status[1:0], direction_changed
);

  logic [1:0]          mode [dpg_pkg::NUM_CFG];
  logic                in_valid_q;
  dpg_pkg::req_t       in_q;
  logic                out_valid_q;
  dpg_pkg::res_t       out_q;
  logic                advance;
  logic [1:0]          dir_a_q [dpg_pkg::GROUPS];
  logic [1:0]          dir_b_q [dpg_pkg::GROUPS];
  logic [1:0]          dir_c_q [dpg_pkg::GROUPS];
  logic [7:0]          lat_a_q [dpg_pkg::GROUPS];
  logic [7:0]          lat_b_q [dpg_pkg::GROUPS];
  logic [7:0]          lat_c_q [dpg_pkg::GROUPS];
  logic [dpg_pkg::GRP_IDX_W-1:0] gidx;
  dpg_pkg::grp_state_t cur;
  dpg_pkg::grp_state_t nxt;
  dpg_pkg::res_t       res;
  logic                upd;

  dpg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.req_type    <= s_axis_tuser[0];
      in_q.group_sel   <= s_axis_tuser[1];
      in_q.channel     <= s_axis_tuser[3:2];
      in_q.write_value <= s_axis_tdata[23:0];
      in_q.pins_a      <= s_axis_tdata[31:24];
      in_q.pins_b      <= s_axis_tdata[39:32];
      in_q.pins_c      <= s_axis_tdata[47:40];
    end
  end

  assign gidx        = dpg_pkg::GRP_IDX_W'(in_q.group_sel);
  assign cur.dir_a   = dir_a_q[gidx];
  assign cur.dir_b   = dir_b_q[gidx];
  assign cur.dir_c   = dir_c_q[gidx];
  assign cur.latch_a = lat_a_q[gidx];
  assign cur.latch_b = lat_b_q[gidx];
  assign cur.latch_c = lat_c_q[gidx];

  dpg_step u_step (
    .req_i  (in_q),
    .mode_i (mode[in_q.group_sel]),
    .cur_i  (cur),
    .nxt_o  (nxt),
    .res_o  (res),
    .upd_o  (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < dpg_pkg::GROUPS; g++) begin
        dir_a_q[g] <= dpg_pkg::DIR_ALL_IN;
        dir_b_q[g] <= dpg_pkg::DIR_ALL_IN;
        dir_c_q[g] <= dpg_pkg::DIR_ALL_IN;
        lat_a_q[g] <= '0;
        lat_b_q[g] <= '0;
        lat_c_q[g] <= '0;
      end
    end else if (advance && upd) begin
      dir_a_q[gidx] <= nxt.dir_a;
      dir_b_q[gidx] <= nxt.dir_b;
      dir_c_q[gidx] <= nxt.dir_c;
      lat_a_q[gidx] <= nxt.latch_a;
      lat_b_q[gidx] <= nxt.latch_b;
      lat_c_q[gidx] <= nxt.latch_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.latch_c, out_q.latch_b, out_q.latch_a,
                          out_q.control_byte, out_q.read_value};
  assign m_axis_tuser  = {out_q.direction_changed, out_q.status};

endmodule

// ===== hdl/dpg_cfg_regs.sv =====
// APB register file holding the grouping mode of each port group.
module dpg_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  mode_o [dpg_pkg::NUM_CFG]
);

  logic [1:0] mode_q [dpg_pkg::NUM_CFG];
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpg_pkg::NUM_CFG; i++) begin
        mode_q[i] <= dpg_pkg::MODE_RESET;
      end
    end else if (wr_en) begin
      mode_q[reg_idx] <= pwdata[1:0];
    end
  end

  assign prdata = {30'd0, mode_q[reg_idx]};
  assign mode_o = mode_q;

endmodule

// ===== hdl/dpg_step.sv =====
// Request decode: channel check, latch and direction update, read assembly.
module dpg_step (
  input  dpg_pkg::req_t       req_i,
  input  logic [1:0]          mode_i,
  input  dpg_pkg::grp_state_t cur_i,
  output dpg_pkg::grp_state_t nxt_o,
  output dpg_pkg::res_t       res_o,
  output logic                upd_o
);

  logic                bad_grp;
  logic                bad_chan;
  logic [1:0]          max_ch;
  logic [23:0]         rv;
  dpg_pkg::grp_state_t nxt;
  logic [23:0]         wv;

  assign bad_grp = 32'(req_i.group_sel) >= dpg_pkg::GROUPS;
  assign wv      = req_i.write_value;

  always_comb begin
    case (mode_i)
      dpg_pkg::MODE_3X8:  max_ch = dpg_pkg::CHAN_2;
      dpg_pkg::MODE_1X24: max_ch = dpg_pkg::CHAN_0;
      default:            max_ch = dpg_pkg::CHAN_1;
    endcase
  end

  assign bad_chan = req_i.channel > max_ch;

  always_comb begin
    nxt = cur_i;
    rv  = '0;
    if (req_i.req_type == dpg_pkg::REQ_WRITE) begin
      case (mode_i)
        dpg_pkg::MODE_3X8: begin
          case (req_i.channel)
            dpg_pkg::CHAN_0: begin
              nxt.latch_a = wv[7:0];
              nxt.dir_a   = dpg_pkg::DIR_ALL_OUT;
            end
            dpg_pkg::CHAN_1: begin
              nxt.latch_b = wv[7:0];
              nxt.dir_b   = dpg_pkg::DIR_ALL_OUT;
            end
            default: begin
              nxt.latch_c = wv[7:0];
              nxt.dir_c   = dpg_pkg::DIR_ALL_OUT;
            end
          endcase
        end
        dpg_pkg::MODE_2X12: begin
          if (req_i.channel == dpg_pkg::CHAN_0) begin
            nxt.latch_a = wv[7:0];
            nxt.dir_a   = dpg_pkg::DIR_ALL_OUT;
            nxt.latch_c = {wv[11:8], cur_i.latch_c[3:0]};
            nxt.dir_c   = cur_i.dir_c & ~dpg_pkg::DIR_HIGH_IN;
          end else begin
            nxt.latch_b = wv[7:0];
            nxt.dir_b   = dpg_pkg::DIR_ALL_OUT;
            nxt.latch_c = {cur_i.latch_c[7:4], wv[11:8]};
            nxt.dir_c   = cur_i.dir_c & ~dpg_pkg::DIR_LOW_IN;
          end
        end
        dpg_pkg::MODE_1X24: begin
          nxt.latch_a = wv[7:0];
          nxt.latch_b = wv[15:8];
          nxt.latch_c = wv[23:16];
          nxt.dir_a   = dpg_pkg::DIR_ALL_OUT;
          nxt.dir_b   = dpg_pkg::DIR_ALL_OUT;
          nxt.dir_c   = dpg_pkg::DIR_ALL_OUT;
        end
        default: begin
          if (req_i.channel == dpg_pkg::CHAN_0) begin
            nxt.latch_a = wv[7:0];
            nxt.latch_b = wv[15:8];
            nxt.dir_a   = dpg_pkg::DIR_ALL_OUT;
            nxt.dir_b   = dpg_pkg::DIR_ALL_OUT;
          end else begin
            nxt.latch_c = wv[7:0];
            nxt.dir_c   = dpg_pkg::DIR_ALL_OUT;
          end
        end
      endcase
    end else begin
      case (mode_i)
        dpg_pkg::MODE_3X8: begin
          case (req_i.channel)
            dpg_pkg::CHAN_0: begin
              nxt.dir_a = dpg_pkg::DIR_ALL_IN;
              rv        = {16'd0, req_i.pins_a};
            end
            dpg_pkg::CHAN_1: begin
              nxt.dir_b = dpg_pkg::DIR_ALL_IN;
              rv        = {16'd0, req_i.pins_b};
            end
            default: begin
              nxt.dir_c = dpg_pkg::DIR_ALL_IN;
              rv        = {16'd0, req_i.pins_c};
            end
          endcase
        end
        dpg_pkg::MODE_2X12: begin
          if (req_i.channel == dpg_pkg::CHAN_0) begin
            nxt.dir_a = dpg_pkg::DIR_ALL_IN;
            nxt.dir_c = cur_i.dir_c | dpg_pkg::DIR_HIGH_IN;
            rv        = {12'd0, req_i.pins_c[7:4], req_i.pins_a};
          end else begin
            nxt.dir_b = dpg_pkg::DIR_ALL_IN;
            nxt.dir_c = cur_i.dir_c | dpg_pkg::DIR_LOW_IN;
            rv        = {12'd0, req_i.pins_c[3:0], req_i.pins_b};
          end
        end
        dpg_pkg::MODE_1X24: begin
          nxt.dir_a = dpg_pkg::DIR_ALL_IN;
          nxt.dir_b = dpg_pkg::DIR_ALL_IN;
          nxt.dir_c = dpg_pkg::DIR_ALL_IN;
          rv        = {req_i.pins_c, req_i.pins_b, req_i.pins_a};
        end
        default: begin
          if (req_i.channel == dpg_pkg::CHAN_0) begin
            nxt.dir_a = dpg_pkg::DIR_ALL_IN;
            nxt.dir_b = dpg_pkg::DIR_ALL_IN;
            rv        = {8'd0, req_i.pins_b, req_i.pins_a};
          end else begin
            nxt.dir_c = dpg_pkg::DIR_ALL_IN;
            rv        = {16'd0, req_i.pins_c};
          end
        end
      endcase
    end
  end

  always_comb begin
    upd_o = 1'b0;
    nxt_o = cur_i;
    res_o = '0;
    if (bad_grp) begin
      res_o.status = dpg_pkg::STATUS_BAD_GROUP;
    end else if (bad_chan) begin
      res_o.status       = dpg_pkg::STATUS_BAD_CHAN;
      res_o.control_byte = dpg_pkg::ctrl_of(cur_i);
      res_o.latch_a      = cur_i.latch_a;
      res_o.latch_b      = cur_i.latch_b;
      res_o.latch_c      = cur_i.latch_c;
    end else begin
      upd_o                   = 1'b1;
      nxt_o                   = nxt;
      res_o.status            = dpg_pkg::STATUS_OK;
      res_o.read_value        = rv;
      res_o.control_byte      = dpg_pkg::ctrl_of(nxt);
      res_o.latch_a           = nxt.latch_a;
      res_o.latch_b           = nxt.latch_b;
      res_o.latch_c           = nxt.latch_c;
      res_o.direction_changed = (nxt.dir_a != cur_i.dir_a) || (nxt.dir_b != cur_i.dir_b)
                                || (nxt.dir_c != cur_i.dir_c);
    end
  end

endmodule

// ===== hdl/dpg_checker.sv =====
// Port-level checker for the port group controller, bound to the top level.
`include "dio_port_group_controller_top_assert.svh"

module dpg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a held result keeps its word
  `DPG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

  // input side only backs up when the result register is full
  `DPG_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with output empty")

  // a rejected request reports no read value and no direction change
  `DPG_ASSERT_NOW(a_reject_clean,
    m_axis_tvalid && (m_axis_tuser[1:0] != dpg_pkg::STATUS_OK),
    !m_axis_tuser[2] && (m_axis_tdata[23:0] == 24'd0), "rejected request has side data")

  // control byte always carries the mode-set flag for a known group
  `DPG_ASSERT_NOW(a_ctrl_flag,
    m_axis_tvalid && (m_axis_tuser[1:0] != dpg_pkg::STATUS_BAD_GROUP),
    m_axis_tdata[31], "control byte missing mode-set flag")

endmodule

bind dio_port_group_controller_top dpg_checker u_dpg_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the digital I/O port group controller.
`timescale 1ns / 100ps

module testbench;

  localparam int REG_GROUP0_MODE = 0;
  localparam int REG_GROUP1_MODE = 1;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_WORDS     = 133;
  localparam int LONG_HOLD       = 120;

  // Tracks mode, directions and latches of each group; predicts every result.
  class port_group_scoreboard;
    logic [1:0]    group_mode [dpg_pkg::GROUPS];
    logic [1:0]    port_dir   [dpg_pkg::GROUPS*3];
    logic [7:0]    port_latch [dpg_pkg::GROUPS*3];
    dpg_pkg::res_t expected_results [$];
    int            errors;

    function new();
      errors = 0;
      foreach (group_mode[i]) group_mode[i] = dpg_pkg::MODE_RESET;
      foreach (port_dir[i]) port_dir[i] = dpg_pkg::DIR_ALL_IN;
      foreach (port_latch[i]) port_latch[i] = 8'h00;
    endfunction

    function void set_mode(int idx, logic [1:0] value);
      group_mode[idx] = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit set_dir(int idx, logic [1:0] code);
      bit changed;
      changed = (port_dir[idx] != code);
      port_dir[idx] = code;
      return changed;
    endfunction

    function dpg_pkg::res_t apply_request(dpg_pkg::req_t r);
      dpg_pkg::res_t e;
      int base;
      int ch;
      logic [1:0] m;
      int maxch;
      bit chg;
      logic [7:0] pins [3];
      e = '0;
      chg = 1'b0;
      if (int'(r.group_sel) >= dpg_pkg::GROUPS) begin
        e.status = dpg_pkg::STATUS_BAD_GROUP;
        return e;
      end
      base = int'(r.group_sel) * 3;
      ch = int'(r.channel);
      m = group_mode[r.group_sel];
      maxch = (m == dpg_pkg::MODE_3X8) ? int'(dpg_pkg::CHAN_2) :
              (m == dpg_pkg::MODE_1X24) ? int'(dpg_pkg::CHAN_0) : int'(dpg_pkg::CHAN_1);
      pins[0] = r.pins_a;
      pins[1] = r.pins_b;
      pins[2] = r.pins_c;
      if (ch > maxch) begin
        e.status = dpg_pkg::STATUS_BAD_CHAN;
      end else if (r.req_type == dpg_pkg::REQ_WRITE) begin
        case (m)
          dpg_pkg::MODE_3X8: begin
            port_latch[base + ch] = r.write_value[7:0];
            chg = set_dir(base + ch, dpg_pkg::DIR_ALL_OUT);
          end
          dpg_pkg::MODE_2X12: begin
            port_latch[base + ch] = r.write_value[7:0];
            chg = set_dir(base + ch, dpg_pkg::DIR_ALL_OUT);
            // each channel owns one nibble of port C
            if (r.channel == dpg_pkg::CHAN_0) begin
              port_latch[base + 2] = {r.write_value[11:8], port_latch[base + 2][3:0]};
              if (set_dir(base + 2, port_dir[base + 2] & ~dpg_pkg::DIR_HIGH_IN)) chg = 1'b1;
            end else begin
              port_latch[base + 2] = {port_latch[base + 2][7:4], r.write_value[11:8]};
              if (set_dir(base + 2, port_dir[base + 2] & ~dpg_pkg::DIR_LOW_IN)) chg = 1'b1;
            end
          end
          dpg_pkg::MODE_1X24: begin
            for (int k = 0; k < 3; k++) begin
              port_latch[base + k] = r.write_value[8*k +: 8];
              if (set_dir(base + k, dpg_pkg::DIR_ALL_OUT)) chg = 1'b1;
            end
          end
          default: begin
            if (r.channel == dpg_pkg::CHAN_0) begin
              port_latch[base]     = r.write_value[7:0];
              port_latch[base + 1] = r.write_value[15:8];
              if (set_dir(base, dpg_pkg::DIR_ALL_OUT)) chg = 1'b1;
              if (set_dir(base + 1, dpg_pkg::DIR_ALL_OUT)) chg = 1'b1;
            end else begin
              port_latch[base + 2] = r.write_value[7:0];
              chg = set_dir(base + 2, dpg_pkg::DIR_ALL_OUT);
            end
          end
        endcase
      end else begin
        case (m)
          dpg_pkg::MODE_3X8: begin
            chg = set_dir(base + ch, dpg_pkg::DIR_ALL_IN);
            e.read_value = {16'h0, pins[ch]};
          end
          dpg_pkg::MODE_2X12: begin
            chg = set_dir(base + ch, dpg_pkg::DIR_ALL_IN);
            if (r.channel == dpg_pkg::CHAN_0) begin
              if (set_dir(base + 2, port_dir[base + 2] | dpg_pkg::DIR_HIGH_IN)) chg = 1'b1;
              e.read_value = {12'h0, r.pins_c[7:4], r.pins_a};
            end else begin
              if (set_dir(base + 2, port_dir[base + 2] | dpg_pkg::DIR_LOW_IN)) chg = 1'b1;
              e.read_value = {12'h0, r.pins_c[3:0], r.pins_b};
            end
          end
          dpg_pkg::MODE_1X24: begin
            for (int k = 0; k < 3; k++)
              if (set_dir(base + k, dpg_pkg::DIR_ALL_IN)) chg = 1'b1;
            e.read_value = {r.pins_c, r.pins_b, r.pins_a};
          end
          default: begin
            if (r.channel == dpg_pkg::CHAN_0) begin
              if (set_dir(base, dpg_pkg::DIR_ALL_IN)) chg = 1'b1;
              if (set_dir(base + 1, dpg_pkg::DIR_ALL_IN)) chg = 1'b1;
              e.read_value = {8'h0, r.pins_b, r.pins_a};
            end else begin
              chg = set_dir(base + 2, dpg_pkg::DIR_ALL_IN);
              e.read_value = {16'h0, r.pins_c};
            end
          end
        endcase
      end
      e.control_byte = dpg_pkg::CTRL_BASE;
      if (port_dir[base] == dpg_pkg::DIR_ALL_IN) e.control_byte |= dpg_pkg::CTRL_A_IN;
      if (port_dir[base + 1] == dpg_pkg::DIR_ALL_IN) e.control_byte |= dpg_pkg::CTRL_B_IN;
      if (port_dir[base + 2][1]) e.control_byte |= dpg_pkg::CTRL_CHI_IN;
      if (port_dir[base + 2][0]) e.control_byte |= dpg_pkg::CTRL_CLO_IN;
      e.latch_a = port_latch[base];
      e.latch_b = port_latch[base + 1];
      e.latch_c = port_latch[base + 2];
      e.direction_changed = chg;
      return e;
    endfunction

    function void note_request(dpg_pkg::req_t r);
      expected_results.push_back(apply_request(r));
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dpg_pkg::res_t got);
      dpg_pkg::res_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 24'(want.status), 24'(got.status));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("control_byte", 24'(want.control_byte), 24'(got.control_byte));
      compare_field("latch_a", 24'(want.latch_a), 24'(got.latch_a));
      compare_field("latch_b", 24'(want.latch_b), 24'(got.latch_b));
      compare_field("latch_c", 24'(want.latch_c), 24'(got.latch_c));
      compare_field("direction_changed", 24'(want.direction_changed),
                    24'(got.direction_changed));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  port_group_scoreboard group_tracker;
  int tx_idle_pct = 27;
  int rx_idle_pct = 27;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  dio_port_group_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("dio_port_group_controller_top verification failed");
      $finish;
    end
  end

  // result side: check each accepted word, random tready, one long hold-off
  initial begin : result_side
    dpg_pkg::res_t got;
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status            = m_axis_tuser[1:0];
        got.direction_changed = m_axis_tuser[2];
        got.read_value        = m_axis_tdata[23:0];
        got.control_byte      = m_axis_tdata[31:24];
        got.latch_a           = m_axis_tdata[39:32];
        got.latch_b           = m_axis_tdata[47:40];
        got.latch_c           = m_axis_tdata[55:48];
        group_tracker.check_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic dpg_pkg::req_t make_req(logic kind, logic grp, logic [1:0] ch,
                                             logic [23:0] val, logic [7:0] a,
                                             logic [7:0] b, logic [7:0] c);
    dpg_pkg::req_t r;
    r.req_type    = kind;
    r.group_sel   = grp;
    r.channel     = ch;
    r.write_value = val;
    r.pins_a      = a;
    r.pins_b      = b;
    r.pins_c      = c;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic dpg_pkg::req_t random_req();
    dpg_pkg::req_t r;
    logic [1:0] m;
    int maxch;
    r.req_type  = logic'($urandom_range(1));
    r.group_sel = logic'($urandom_range(1));
    m = group_tracker.group_mode[r.group_sel];
    maxch = (m == dpg_pkg::MODE_3X8) ? 2 : (m == dpg_pkg::MODE_1X24) ? 0 : 1;
    // mostly legal channels so the latch and direction paths get exercised
    if ($urandom_range(99) < 85) r.channel = 2'($urandom_range(maxch));
    else r.channel = 2'($urandom_range(3));
    r.write_value = {random_byte(), random_byte(), random_byte()};
    r.pins_a = random_byte();
    r.pins_b = random_byte();
    r.pins_c = random_byte();
    return r;
  endfunction

  task automatic send_request(input dpg_pkg::req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.pins_c, r.pins_b, r.pins_a, r.write_value};
    s_axis_tuser  <= {r.channel, r.group_sel, r.req_type};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    group_tracker.note_request(r);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (group_tracker.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input int reg_idx, input logic [1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * reg_idx);
    pwdata  <= {30'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    group_tracker.set_mode(reg_idx, value);
  endtask

  task automatic set_modes(input logic [1:0] m0, input logic [1:0] m1);
    wait_idle();
    apb_write(REG_GROUP0_MODE, m0);
    apb_write(REG_GROUP1_MODE, m1);
  endtask

  initial begin : stimulus
    logic [1:0] m;
    logic g;
    group_tracker = new();
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode, every legal channel written at the extremes, then read
    for (int mi = 0; mi < 4; mi++) begin
      m = 2'(mi);
      g = m[0];
      set_modes(m, m);
      for (int ch = 0; ch < 3; ch++) begin
        send_request(make_req(dpg_pkg::REQ_WRITE, g, 2'(ch),
                              (ch == 1) ? 24'h000000 : 24'hFFFFFF,
                              8'h00, 8'h00, 8'h00));
        send_request(make_req(dpg_pkg::REQ_READ, g, 2'(ch), 24'h000000,
                              8'hFF, 8'h00, (ch == 1) ? 8'h0F : 8'hF0));
      end
    end
    send_request(make_req(dpg_pkg::REQ_WRITE, 1'b0, 2'd3, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_modes(dpg_pkg::MODE_3X8, dpg_pkg::MODE_16P8);
        1: set_modes(dpg_pkg::MODE_16P8, dpg_pkg::MODE_3X8);
        2: set_modes(dpg_pkg::MODE_2X12, dpg_pkg::MODE_1X24);
        default: set_modes(2'($urandom_range(3)), 2'($urandom_range(3)));
      endcase
      // one phase runs with no idling on either side
      tx_idle_pct = (ph == 3) ? 0 : 27;
      rx_idle_pct = (ph == 3) ? 0 : 27;
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++)
        send_request(random_req());
    end

    wait_idle();
    group_tracker.errors += group_tracker.pending();
    if (group_tracker.errors == 0) begin
      $display("dio_port_group_controller_top verification clean");
    end else begin
      $display("dio_port_group_controller_top verification failed");
    end
    $finish;
  end

endmodule
